### sv/assert_macros.svh
// assertion macros used by utf8_stream_decoder
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

### sv/utf8d_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8d_pkg
// Types and constants for the streaming utf-8 decoder.
// ----------------------------------------------------------------------------
package utf8d_pkg;

  localparam int unsigned CountW = 16;
  localparam int unsigned CodeW  = 21;
  localparam int unsigned PaddrW = 2;
  localparam logic [CountW-1:0] LimitReset = 16'hFFFF;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_STRAY      = 3'd1,
    ST_MALFORMED  = 3'd2,
    ST_INCOMPLETE = 3'd3,
    ST_LIMIT      = 3'd4,
    ST_END        = 3'd5
  } status_e;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [CodeW-1:0]  code_point;
    logic              char_valid;
    status_e           status;
    logic              finished;
    logic [CountW-1:0] chars_out;
  } out_item_t;

  typedef struct packed {
    logic [1:0]        bytes_pending;
    logic [CodeW-1:0]  partial_value;
    logic              sequence_bad;
    logic              halted;
    logic [CountW-1:0] char_count;
  } dec_state_t;

endpackage

### sv/utf8d_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8d_cfg
// Register port holding the per-buffer character limit.
// ----------------------------------------------------------------------------
module utf8d_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [utf8d_pkg::PaddrW-1:0]        paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready,
  output logic [utf8d_pkg::CountW-1:0]        limit_o
);
  import utf8d_pkg::*;

  logic [CountW-1:0] limit_q;
  logic              wr_en;

  // the limit is the only register, at address 0
  assign wr_en  = psel && penable && pwrite && (paddr == '0);
  assign pready = 1'b1;
  assign prdata = {{(32-CountW){1'b0}}, limit_q};
  assign limit_o = limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LimitReset;
    end else if (wr_en) begin
      limit_q <= pwdata[CountW-1:0];
    end
  end

endmodule

### sv/utf8d_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8d_step
// Next-state and result logic for one byte of the stream.
// ----------------------------------------------------------------------------
module utf8d_step (
  input  utf8d_pkg::dec_state_t        state_i,
  input  utf8d_pkg::in_item_t          item_i,
  input  logic [utf8d_pkg::CountW-1:0] limit_i,
  output utf8d_pkg::dec_state_t        state_o,
  output logic                         have_o,
  output utf8d_pkg::out_item_t         result_o
);
  import utf8d_pkg::*;

  dec_state_t       nxt;
  logic             have;
  logic             valid;
  logic             fin;
  status_e          status;
  logic [CodeW-1:0] cp;
  logic [7:0]       b;
  logic [CountW-1:0] count_out;

  assign b = item_i.byte_value;

  always_comb begin
    nxt    = state_i;
    have   = 1'b0;
    valid  = 1'b0;
    fin    = 1'b0;
    status = ST_OK;
    cp     = '0;

    if (!state_i.halted) begin
      if (state_i.char_count >= limit_i) begin
        have = 1'b1; status = ST_LIMIT; fin = 1'b1; nxt.halted = 1'b1;
      end else if (state_i.bytes_pending == 2'd0) begin
        nxt.sequence_bad = 1'b0;
        if (b[7] == 1'b0) begin
          cp = {{(CodeW-8){1'b0}}, b};
          valid = 1'b1;
        end else if (b[7:5] == 3'b110) begin
          nxt.partial_value = {{(CodeW-5){1'b0}}, b[4:0]};
          nxt.bytes_pending = 2'd1;
        end else if (b[7:4] == 4'b1110) begin
          nxt.partial_value = {{(CodeW-4){1'b0}}, b[3:0]};
          nxt.bytes_pending = 2'd2;
        end else if (b[7:3] == 5'b11110) begin
          nxt.partial_value = {{(CodeW-3){1'b0}}, b[2:0]};
          nxt.bytes_pending = 2'd3;
        end else if (b[7:6] == 2'b10) begin
          have = 1'b1; status = ST_STRAY;
        end else begin
          have = 1'b1; status = ST_MALFORMED; fin = 1'b1; nxt.halted = 1'b1;
        end
      end else begin
        if (b[7:6] != 2'b10) begin
          nxt.sequence_bad = 1'b1;
        end
        nxt.partial_value = {state_i.partial_value[CodeW-7:0], b[5:0]};
        nxt.bytes_pending = state_i.bytes_pending - 2'd1;
        if (nxt.bytes_pending == 2'd0) begin
          if (nxt.sequence_bad) begin
            have = 1'b1; status = ST_MALFORMED; fin = 1'b1; nxt.halted = 1'b1;
          end else begin
            cp = nxt.partial_value;
            valid = 1'b1;
          end
        end
      end

      if (valid) begin
        have = 1'b1;
        nxt.char_count = state_i.char_count + 1'b1;
        if (nxt.char_count >= limit_i) begin
          status = ST_LIMIT; fin = 1'b1; nxt.halted = 1'b1;
        end
      end

      // end of buffer closes whatever is still open
      if (item_i.last_byte && !fin) begin
        have = 1'b1;
        fin  = 1'b1;
        if (nxt.bytes_pending != 2'd0) begin
          status = ST_INCOMPLETE;
        end else if (status == ST_OK) begin
          status = ST_END;
        end
      end
    end

    count_out = nxt.char_count;
    if (item_i.last_byte) begin
      nxt = '0;
    end
  end

  assign state_o             = nxt;
  assign have_o              = have;
  assign result_o.code_point = cp;
  assign result_o.char_valid = valid;
  assign result_o.status     = status;
  assign result_o.finished   = fin;
  assign result_o.chars_out  = count_out;

endmodule

### sv/utf8_stream_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// Streaming utf-8 decoder: one byte per item in, zero or one result per byte.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid_i / in_stall_o / in_data_i) carries one byte
//   per item with a flag on the last byte of a buffer. The output channel
//   (out_valid_o / out_stall_i / out_data_o) carries decoded code points and
//   status items; lead bytes, middle continuation bytes and bytes after a
//   stop produce no item.
//   An accepted byte lands in an input register and is decoded from there;
//   its result is written to the output register, which offers it.
//   One byte is taken every cycle while in_stall_o is low; the decode state updates in a single
//   pass between the input and output registers.
//   When the receiver stalls, the output register holds its item and the
//   input register holds the next byte; in_stall_o rises only when that
//   byte would produce a result and the output register cannot take it.
//   Reset clears the decode state and sets the character limit to 65535.
//   The limit register sits at address 0 of the register port and should
//   only be written while no buffer is in flight.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module utf8_stream_decoder (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  utf8d_pkg::in_item_t           in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output utf8d_pkg::out_item_t          out_data_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [utf8d_pkg::PaddrW-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import utf8d_pkg::*;

  logic [CountW-1:0] limit;
  logic              in_valid_q;
  in_item_t          in_item_q;
  dec_state_t        state_q;
  dec_state_t        state_d;
  logic              have;
  out_item_t         result;
  logic              out_valid_q;
  out_item_t         out_item_q;
  logic              out_free;
  logic              advance;

  utf8d_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .limit_o (limit)
  );

  utf8d_step u_step (
    .state_i  (state_q),
    .item_i   (in_item_q),
    .limit_i  (limit),
    .state_o  (state_d),
    .have_o   (have),
    .result_o (result)
  );

  // a byte with no result never waits on the output side
  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && (!have || out_free);
  assign in_stall_o = in_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_item_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && have) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && have) begin
      out_item_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_item_q;

  `ASSERT_CLK(a_char_counted, clk_i, rst_ni, out_valid_o && out_data_o.char_valid |-> out_data_o.chars_out != '0, "character result with zero count")
  `ASSERT_CLK(a_empty_code, clk_i, rst_ni, out_valid_o && !out_data_o.char_valid |-> out_data_o.code_point == '0, "code point set without a character")
  `ASSERT_CLK(a_stop_finishes, clk_i, rst_ni, out_valid_o && (out_data_o.status == ST_MALFORMED || out_data_o.status == ST_INCOMPLETE || out_data_o.status == ST_LIMIT || out_data_o.status == ST_END) |-> out_data_o.finished, "stop status without finished")
  `ASSERT_CLK(a_stall_needs_item, clk_i, rst_ni, in_stall_o |-> in_valid_q && out_valid_q && out_stall_i, "input stalled without a blocked result")

endmodule
